// ===== rtl/tams_pkg.sv =====
// Package for the three-axis statistics block: shared widths and the
// record passed from the accumulator front to the statistics back end.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tams_pkg;
  localparam int SUM_BITS = 33;
  localparam int SQ_BITS  = 47;

  // One closed window as handed from front to back.
  typedef struct packed {
    logic [2:0][SUM_BITS-1:0] sum;
    logic [2:0][SQ_BITS-1:0]  sq;
    logic [19:0]              count;
    logic                     ovf;
  } window_t;
endpackage
`default_nettype wire

// ===== rtl/three_axis_mean_std_rms.sv =====
// Top level of the three-axis mean / standard deviation / RMS block.
// Depends on tams_pkg, tams_front and tams_back.
//
// Usage: one x,y,z sample transfer per cycle on the input channel
// (in_valid/in_stall); last_sample closes the window. Samples past
// MAX_SAMPLES are dropped and reported by count_overflow.
// Accumulation runs at one sample a cycle while in_stall is low. When a
// window closes, the back end computes each axis in turn: mean, variance
// and RMS each take a serial divide, and the latter two a square root;
// out_valid rises once all three axes are done. One closed window may
// wait between the front and the back; while it waits for the busy back
// end, every input transfer stalls. A stalled result holds until
// out_stall drops.
// Reset (rst, synchronous) clears all sums and drops both valids.
`timescale 1ns / 1ps
`default_nettype none
module three_axis_mean_std_rms #(
  parameter int MAX_SAMPLES = 65535,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] accel_x,
  input  wire logic signed [15:0] accel_y,
  input  wire logic signed [15:0] accel_z,
  input  wire logic               last_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      mean_x,
  output logic signed [15:0]      mean_y,
  output logic signed [15:0]      mean_z,
  output logic [14:0]             std_x,
  output logic [14:0]             std_y,
  output logic [14:0]             std_z,
  output logic [15:0]             rms_x,
  output logic [15:0]             rms_y,
  output logic [15:0]             rms_z,
  output logic [15:0]             sample_count,
  output logic                    count_overflow
);
  tams_pkg::window_t win;
  logic win_valid, win_stall;
  logic [2:0][15:0] mean, rms;
  logic [2:0][14:0] sd;

  tams_front #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .ax(accel_x), .ay(accel_y), .az(accel_z),
    .last(last_sample), .win_valid, .win_stall, .win);

  tams_back u_back (
    .clk, .rst, .win_valid, .win_stall, .win, .out_valid, .out_stall,
    .mean, .sd, .rms, .cnt(sample_count), .ovf(count_overflow));

  assign mean_x = mean[0]; assign mean_y = mean[1]; assign mean_z = mean[2];
  assign std_x = sd[0]; assign std_y = sd[1]; assign std_z = sd[2];
  assign rms_x = rms[0]; assign rms_y = rms[1]; assign rms_z = rms[2];
endmodule
`default_nettype wire

// ===== rtl/tams_front.sv =====
// Accumulator front end: counts samples and keeps per-axis sums.
// Depends on tams_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tams_front #(
  parameter int MAX_SAMPLES = 65535,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] ax,
  input  wire logic signed [15:0] ay,
  input  wire logic signed [15:0] az,
  input  wire logic               last,
  output logic                    win_valid,
  input  wire logic               win_stall,
  output tams_pkg::window_t       win
);
  localparam int SB = tams_pkg::SUM_BITS;
  localparam int QB = tams_pkg::SQ_BITS;

  logic [2:0][SB-1:0] sum;
  logic [2:0][QB-1:0] sq;
  logic [19:0]        count;
  logic               ovf;
  logic               take;
  logic               room;
  logic [2:0][SAMPLE_BITS-1:0] smp;

  // The low SAMPLE_BITS bits of each input form the two's complement sample.
  assign smp      = {SAMPLE_BITS'($unsigned(az)), SAMPLE_BITS'($unsigned(ay)),
                     SAMPLE_BITS'($unsigned(ax))};
  // The closed-window register must be free before a last sample is taken.
  assign in_stall = win_valid && win_stall;
  assign take     = in_valid && !in_stall;
  assign room     = count < 20'(MAX_SAMPLES);

  // Accumulate, and on the last sample hand the finished window over.
  always_ff @(posedge clk) begin
    logic [2:0][SB-1:0] s_n;
    logic [2:0][QB-1:0] q_n;
    logic signed [SAMPLE_BITS-1:0] v;
    logic [SAMPLE_BITS-1:0] m;
    logic [2*SAMPLE_BITS-1:0] m2;
    for (int a = 0; a < 3; a++) begin
      v = smp[a];
      m = v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
      m2 = {{SAMPLE_BITS{1'b0}}, m} * {{SAMPLE_BITS{1'b0}}, m};
      s_n[a] = room ? sum[a] + SB'(v) : sum[a];
      q_n[a] = room ? sq[a] + QB'(m2) : sq[a];
    end
    if (rst) begin
      sum <= '0; sq <= '0; count <= '0; ovf <= 1'b0; win_valid <= 1'b0;
    end else begin
      if (take && last) win_valid <= 1'b1;
      else if (win_valid && !win_stall) win_valid <= 1'b0;
      if (take) begin
        if (last) begin
          win.sum   <= s_n;
          win.sq    <= q_n;
          win.count <= room ? count + 20'd1 : count;
          win.ovf   <= ovf || !room;
          sum <= '0; sq <= '0; count <= '0; ovf <= 1'b0;
        end else begin
          sum <= s_n; sq <= q_n;
          if (room) count <= count + 20'd1;
          else ovf <= 1'b1;
        end
      end
    end
  end

  // Counter never passes the window limit.
  a_cnt: assert property (@(posedge clk) disable iff (rst) count <= 20'(MAX_SAMPLES))
    else $error("count past limit");
  // A held window stays put while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    win_valid && win_stall |=> win_valid && $stable(win)) else $error("window lost");
  // Overflow only once the window is full.
  a_ovf: assert property (@(posedge clk) disable iff (rst)
    $rose(ovf) |-> $past(count) == 20'(MAX_SAMPLES)) else $error("early overflow");
endmodule
`default_nettype wire

// ===== rtl/tams_back.sv =====
// Statistics back end: serial divides and square roots per axis.
// Depends on tams_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tams_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         win_valid,
  output logic              win_stall,
  input  tams_pkg::window_t win,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [2:0][15:0]  mean,
  output logic [2:0][14:0]  sd,
  output logic [2:0][15:0]  rms,
  output logic [15:0]       cnt,
  output logic              ovf
);
  localparam int SB = tams_pkg::SUM_BITS;
  localparam int QB = tams_pkg::SQ_BITS;
  localparam int W  = 68;

  localparam logic [2:0] S_IDLE = 3'd0, S_PREP = 3'd1, S_MUL = 3'd2,
                         S_DIV = 3'd3, S_SQRT = 3'd4, S_OUT = 3'd5;
  localparam logic [1:0] J_MEAN = 2'd0, J_VAR = 2'd1, J_RMS = 2'd2;

  logic [2:0]  state;
  logic [1:0]  axis, job;
  logic [6:0]  step;
  tams_pkg::window_t w;
  logic [W-1:0] dvd, rem, den, prod, rhs;
  logic [W-1:0] sv, root, bitv;
  logic [32:0]  mag;
  logic         neg;
  logic [W:0]   trial;
  logic [W-1:0] rs;

  assign win_stall = state != S_IDLE;
  assign trial = {rem[W-2:0], dvd[W-1]} - {1'b0, den};
  assign rs    = root + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (win_valid) begin
          w <= win; axis <= 2'd0; job <= J_MEAN; state <= S_PREP;
          out_valid <= 1'b0;
        end
        // Set up the job for this axis: mean, variance or rms; an empty window zeroes all three.
        S_PREP: begin
          neg <= w.sum[axis][SB-1];
          mag <= w.sum[axis][SB-1] ? 33'(-w.sum[axis]) : w.sum[axis];
          step <= '0; rem <= '0;
          den <= W'(w.count);
          if (w.count == 20'd0) begin
            mean[axis] <= '0; sd[axis] <= '0; rms[axis] <= '0;
            job <= J_MEAN;
            if (axis == 2'd2) state <= S_OUT; else axis <= axis + 2'd1;
          end else if (job == J_MEAN) begin
            dvd <= W'(w.sum[axis][SB-1] ? 33'(-w.sum[axis]) : w.sum[axis]);
            state <= S_DIV;
          end else if (job == J_VAR) begin
            state <= S_MUL;
          end else begin
            dvd <= W'(w.sq[axis]); state <= S_DIV;
          end
        end
        // Form n*sq - sum^2 and n^2, products kept to 64 bits.
        S_MUL: begin
          case (step)
            7'd0: begin
              prod <= W'(w.count) * W'(w.sq[axis][23:0]);
              rhs  <= W'(mag) * W'(mag);
              den  <= W'(w.count) * W'(w.count);
              step <= 7'd1;
            end
            7'd1: begin
              dvd <= prod + ((W'(w.count) * W'(w.sq[axis][QB-1:24])) << 24);
              step <= 7'd2;
            end
            default: begin
              dvd <= (dvd[63:0] > rhs[63:0]) ? W'(dvd[63:0] - rhs[63:0]) : '0;
              step <= '0; state <= S_DIV;
            end
          endcase
        end
        // Restoring divide, one quotient bit a cycle.
        S_DIV: begin
          if (!trial[W]) begin
            rem <= trial[W-1:0]; dvd <= {dvd[W-2:0], 1'b1};
          end else begin
            rem <= {rem[W-2:0], dvd[W-1]}; dvd <= {dvd[W-2:0], 1'b0};
          end
          step <= (step == 7'(W-1)) ? '0 : step + 7'd1;
          if (step == 7'(W-1)) begin
            if (job == J_MEAN) begin
              mean[axis] <= neg ? 16'(-{dvd[W-2:0], !trial[W]})
                                : 16'({dvd[W-2:0], !trial[W]});
              job <= J_VAR; state <= S_PREP;
            end else begin
              sv <= {dvd[W-2:0], !trial[W]};
              root <= '0; bitv <= W'(1) << (W-2);
              state <= S_SQRT;
            end
          end
        end
        // Bitwise integer square root, two radicand bits consumed per result bit.
        S_SQRT: begin
          if (sv >= rs) begin
            sv <= sv - rs; root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv == W'(1)) begin
            if (job == J_VAR) begin
              sd[axis] <= (sv >= rs) ? (((root >> 1) + bitv) > W'(32767) ? 15'h7fff
                         : 15'((root >> 1) + bitv))
                         : ((root >> 1) > W'(32767) ? 15'h7fff : 15'(root >> 1));
              job <= J_RMS; state <= S_PREP;
            end else begin
              rms[axis] <= (sv >= rs) ? (((root >> 1) + bitv) > W'(65535) ? 16'hffff
                          : 16'((root >> 1) + bitv))
                          : ((root >> 1) > W'(65535) ? 16'hffff : 16'(root >> 1));
              job <= J_MEAN;
              if (axis == 2'd2) state <= S_OUT;
              else begin axis <= axis + 2'd1; state <= S_PREP; end
            end
          end
        end
        S_OUT: begin
          cnt <= w.count[15:0]; ovf <= w.ovf;
          if (!out_valid) out_valid <= 1'b1;
          else if (!out_stall) begin out_valid <= 1'b0; state <= S_IDLE; end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result stays put while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mean) && $stable(sd))
    else $error("result changed");
  // Result only shown in the output state.
  a_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_OUT) else $error("stray valid");
  // Window taken only when idle.
  a_take: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && win_valid |=> state == S_PREP) else $error("window missed");
endmodule
`default_nettype wire
